/* rtl/sparse_set_integer_domain_macros.svh */
`ifndef SPARSE_SET_INTEGER_DOMAIN_MACROS_SVH
`define SPARSE_SET_INTEGER_DOMAIN_MACROS_SVH

// concurrent checks, disabled while reset is low
`define SSID_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SSID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ssid_pkg.sv */
package ssid_pkg;

    typedef logic [2:0] t_req;
    localparam t_req REQ_INIT     = 3'd0;
    localparam t_req REQ_SELECT   = 3'd1;
    localparam t_req REQ_MARK     = 3'd2;
    localparam t_req REQ_BIND     = 3'd3;
    localparam t_req REQ_REMOVE   = 3'd4;
    localparam t_req REQ_RESTRICT = 3'd5;
    localparam t_req REQ_RAISE    = 3'd6;
    localparam t_req REQ_LOWER    = 3'd7;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_BASE     = 2'd0;
    localparam t_reg_idx REG_SPAN     = 2'd1;
    localparam t_reg_idx REG_STRATEGY = 2'd2;

    typedef logic [1:0] t_strat;
    localparam t_strat STRAT_FIRST = 2'd0;
    localparam t_strat STRAT_MIN   = 2'd1;
    localparam t_strat STRAT_MAX   = 2'd2;

    typedef struct packed {
        logic ev_min;
        logic ev_max;
        logic ev_change;
        logic ev_bind;
    } t_events;

endpackage

/* rtl/ssid_ram.sv */
module ssid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/sparse_set_integer_domain.sv */
// Select, restrict and bound updates without bind pass through RD, EX and DONE
// from accept to result valid; a swap of two entries (bind, mark, remove) adds
// the write states W1 and W2, and a remove that leaves one value adds R0 and R1
// for reading entry 0. Init runs LOAD, then INIT fills each span entry of both RAMs.
// One request at a time; throughput is set by the memory read/write sequence.
// Reset is synchronous; afterwards an init sweep runs before ready.
`include "sparse_set_integer_domain_macros.svh"

module sparse_set_integer_domain #(
    parameter int DEPTH = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  ssid_pkg::t_req       i_req_type,
    input  logic signed [31:0]   i_value,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_ok,
    output logic signed [31:0]   o_selected_value,
    output logic                 o_ev_min,
    output logic                 o_ev_max,
    output logic                 o_ev_change,
    output logic                 o_ev_bind,
    output logic [8:0]           o_domain_size,
    output logic signed [31:0]   o_cur_min,
    output logic signed [31:0]   o_cur_max
);
    import ssid_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int BW = CW + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LOAD = 4'd1;
    localparam logic [3:0] S_INIT = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_EX   = 4'd4;
    localparam logic [3:0] S_W1   = 4'd5;
    localparam logic [3:0] S_W2   = 4'd6;
    localparam logic [3:0] S_R0   = 4'd7;
    localparam logic [3:0] S_R1   = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    // configuration
    logic signed [15:0] r_base;
    logic [8:0]         r_span;
    t_strat             r_strat;

    // domain state
    logic [3:0]            r_state, n_state;
    t_req                  r_req, n_req;
    logic signed [33:0]    r_off, n_off;
    logic [AW-1:0]         r_i, n_i, r_b, n_b, r_j, n_j, r_k, n_k;
    logic                  r_need_w, n_need_w;
    logic                  r_pend, n_pend;
    logic                  r_ok, n_ok;
    logic signed [31:0]    r_sel, n_sel;
    t_events               r_ev, n_ev;
    logic signed [15:0]    r_act_base, n_act_base;
    logic [CW-1:0]         r_act_span, n_act_span;
    logic [CW-1:0]         r_live, n_live, r_mc, n_mc;
    logic signed [BW-1:0]  r_lo, n_lo, r_hi, n_hi, r_ml, n_ml, r_mh, n_mh;

    // output register
    logic                  r_ov, n_ov;
    logic                  r_o_ok, n_o_ok;
    logic signed [31:0]    r_o_sel, n_o_sel, r_o_min, n_o_min, r_o_max, n_o_max;
    t_events               r_o_ev, n_o_ev;
    logic [8:0]            r_o_size, n_o_size;

    // memories
    logic          val_we, pos_we;
    logic [AW-1:0] val_waddr, val_wdata, val_raddr, val_rdata;
    logic [AW-1:0] pos_waddr, pos_wdata, pos_raddr, pos_rdata;

    // decode helpers
    logic signed [33:0] lo34, hi34, span34, w34;
    logic               found, in_bnd, pi_live, cfg_wr;
    logic [AW-1:0]      off_a;
    logic signed [BW-1:0] off_bw, w_bw;
    logic [CW-1:0]      live_m1;
    logic [8:0]         span_nz;

    ssid_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_values (
        .i_clk  (i_clk),
        .i_we   (val_we),
        .i_waddr(val_waddr),
        .i_wdata(val_wdata),
        .i_raddr(val_raddr),
        .o_rdata(val_rdata)
    );

    ssid_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_positions (
        .i_clk  (i_clk),
        .i_we   (pos_we),
        .i_waddr(pos_waddr),
        .i_wdata(pos_wdata),
        .i_raddr(pos_raddr),
        .o_rdata(pos_rdata)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_BASE:     prdata = {16'd0, r_base};
            REG_SPAN:     prdata = {23'd0, r_span};
            REG_STRATEGY: prdata = {30'd0, r_strat};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= 16'sd0;
            r_span  <= 9'd256;
            r_strat <= STRAT_FIRST;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_BASE:     r_base  <= pwdata[15:0];
                REG_SPAN:     r_span  <= pwdata[8:0];
                REG_STRATEGY: r_strat <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);

    assign lo34    = 34'(r_lo);
    assign hi34    = 34'(r_hi);
    assign span34  = 34'($signed({1'b0, r_act_span}));
    assign w34     = 34'($signed({1'b0, val_rdata}));
    assign found   = (r_off >= 34'sd0) && (r_off < span34);
    assign in_bnd  = (r_off >= lo34) && (r_off <= hi34);
    assign pi_live = CW'(pos_rdata) < r_live;
    assign off_a   = r_off[AW-1:0];
    assign off_bw  = BW'(r_off);
    assign w_bw    = BW'($signed({1'b0, val_rdata}));
    assign live_m1 = r_live - CW'(1);
    assign span_nz = (r_span == 9'd0) ? 9'd1 : r_span;

    // memory ports
    always_comb begin
        val_we    = 1'b0;
        pos_we    = 1'b0;
        val_waddr = r_k;
        val_wdata = r_k;
        pos_waddr = r_k;
        pos_wdata = r_k;
        val_raddr = '0;
        pos_raddr = off_a;
        case (r_state)
            S_INIT: begin
                val_we = 1'b1;
                pos_we = 1'b1;
            end
            S_W1: begin
                val_we    = 1'b1;
                val_waddr = r_i;
                val_wdata = r_b;
                pos_we    = 1'b1;
                pos_waddr = off_a;
                pos_wdata = r_j;
            end
            S_W2: begin
                val_we    = 1'b1;
                val_waddr = r_j;
                val_wdata = off_a;
                pos_we    = 1'b1;
                pos_waddr = r_b;
                pos_wdata = r_i;
            end
            S_RD: begin
                if (r_req == REQ_MARK) begin
                    val_raddr = r_mc[AW-1:0];
                end else if (r_req == REQ_REMOVE) begin
                    val_raddr = live_m1[AW-1:0];
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_off      = r_off;
        n_i        = r_i;
        n_b        = r_b;
        n_j        = r_j;
        n_k        = r_k;
        n_need_w   = r_need_w;
        n_pend     = r_pend;
        n_ok       = r_ok;
        n_sel      = r_sel;
        n_ev       = r_ev;
        n_act_base = r_act_base;
        n_act_span = r_act_span;
        n_live     = r_live;
        n_mc       = r_mc;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_ml       = r_ml;
        n_mh       = r_mh;
        n_ov       = r_ov && !i_ready;
        n_o_ok     = r_o_ok;
        n_o_sel    = r_o_sel;
        n_o_min    = r_o_min;
        n_o_max    = r_o_max;
        n_o_ev     = r_o_ev;
        n_o_size   = r_o_size;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req    = i_req_type;
                    n_off    = 34'(i_value) - 34'(r_act_base);
                    n_ok     = 1'b1;
                    n_sel    = 32'sd0;
                    n_ev     = '0;
                    n_need_w = 1'b0;
                    n_pend   = 1'b1;
                    if (i_req_type != REQ_MARK && i_req_type != REQ_RESTRICT) begin
                        n_mc = '0;
                        n_ml = r_hi + BW'(1);
                        n_mh = r_lo - BW'(1);
                    end
                    n_state = (i_req_type == REQ_INIT) ? S_LOAD : S_RD;
                end
            end
            S_LOAD: begin
                n_act_base = r_base;
                n_act_span = (32'(r_span) > DEPTH) ? CW'(DEPTH) : CW'(span_nz);
                n_k        = '0;
                n_state    = S_INIT;
            end
            S_INIT: begin
                n_k = r_k + AW'(1);
                if (CW'(r_k) == r_act_span - CW'(1)) begin
                    n_live  = r_act_span;
                    n_lo    = '0;
                    n_hi    = BW'(r_act_span) - BW'(1);
                    n_mc    = '0;
                    n_ml    = BW'(r_act_span);
                    n_mh    = -BW'(1);
                    n_state = r_pend ? S_DONE : S_IDLE;
                end
            end
            S_RD: n_state = S_EX;
            S_EX: begin
                n_state = S_DONE;
                n_i     = pos_rdata;
                n_b     = val_rdata;
                case (r_req) inside
                    REQ_SELECT: begin
                        case (r_strat)
                            STRAT_MIN: n_sel = 32'(r_lo) + 32'(r_act_base);
                            STRAT_MAX: n_sel = 32'(r_hi) + 32'(r_act_base);
                            default:   n_sel = 32'(val_rdata) + 32'(r_act_base);
                        endcase
                    end
                    REQ_MARK: begin
                        if (in_bnd && found && pi_live && CW'(pos_rdata) >= r_mc) begin
                            n_j     = r_mc[AW-1:0];
                            n_mc    = r_mc + CW'(1);
                            n_state = S_W1;
                            if (off_bw < r_ml) n_ml = off_bw;
                            if (off_bw > r_mh) n_mh = off_bw;
                        end
                    end
                    REQ_REMOVE: begin
                        if (found && pi_live) begin
                            if (r_live <= CW'(1)) begin
                                n_ok = 1'b0;
                            end else begin
                                n_live  = live_m1;
                                n_j     = live_m1[AW-1:0];
                                n_state = S_W1;
                                if (live_m1 == CW'(1)) begin
                                    n_need_w = 1'b1;
                                end else begin
                                    n_ev.ev_change = 1'b1;
                                    if (r_off == lo34) begin
                                        n_lo = r_lo + BW'(1);
                                        n_ev.ev_min = 1'b1;
                                    end
                                    if (r_off == hi34) begin
                                        n_hi = r_hi - BW'(1);
                                        n_ev.ev_max = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                    REQ_RESTRICT: begin
                        n_mc = '0;
                        n_ml = r_hi + BW'(1);
                        n_mh = r_lo - BW'(1);
                        if (r_mc != r_live) begin
                            n_live = r_mc;
                            if (r_mc == '0) begin
                                n_ok = 1'b0;
                            end else begin
                                n_lo = r_ml;
                                n_hi = r_mh;
                                n_ev.ev_min    = (r_lo != r_ml);
                                n_ev.ev_max    = (r_hi != r_mh);
                                n_ev.ev_change = 1'b1;
                                n_ev.ev_bind   = (r_mc == CW'(1));
                            end
                        end
                    end
                    REQ_BIND, REQ_RAISE, REQ_LOWER: begin
                        if (r_req == REQ_RAISE && r_off <= lo34) begin
                            n_ok = 1'b1;
                        end else if (r_req == REQ_LOWER && r_off >= hi34) begin
                            n_ok = 1'b1;
                        end else if (r_req == REQ_RAISE && r_off > hi34) begin
                            n_ok = 1'b0;
                        end else if (r_req == REQ_LOWER && r_off < lo34) begin
                            n_ok = 1'b0;
                        end else if (r_req == REQ_RAISE && r_off != hi34) begin
                            n_lo = off_bw;
                            n_ev.ev_change = 1'b1;
                            n_ev.ev_min    = 1'b1;
                        end else if (r_req == REQ_LOWER && r_off != lo34) begin
                            n_hi = off_bw;
                            n_ev.ev_change = 1'b1;
                            n_ev.ev_max    = 1'b1;
                        end else if (!in_bnd || !found || !pi_live) begin
                            // bind to a value that is not live
                            n_ok = 1'b0;
                        end else if (r_live != CW'(1)) begin
                            n_j     = '0;
                            n_live  = CW'(1);
                            n_lo    = off_bw;
                            n_hi    = off_bw;
                            n_state = S_W1;
                            n_ev.ev_min    = (r_off != lo34);
                            n_ev.ev_max    = (r_off != hi34);
                            n_ev.ev_change = 1'b1;
                            n_ev.ev_bind   = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_W1: n_state = S_W2;
            S_W2: n_state = r_need_w ? S_R0 : S_DONE;
            S_R0: n_state = S_R1;
            S_R1: begin
                // one value left: both bounds collapse onto it
                n_state = S_DONE;
                if (w34 < lo34 || w34 > hi34) begin
                    n_ok = 1'b0;
                end else begin
                    n_lo = w_bw;
                    n_hi = w_bw;
                    n_ev.ev_min    = (w_bw != r_lo);
                    n_ev.ev_max    = (w_bw != r_hi);
                    n_ev.ev_change = 1'b1;
                    n_ev.ev_bind   = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_ov || i_ready) begin
                    n_ov     = 1'b1;
                    n_o_ok   = r_ok;
                    n_o_sel  = r_sel;
                    n_o_ev   = r_ev;
                    n_o_size = 9'(32'(r_live));
                    n_o_min  = 32'(r_lo) + 32'(r_act_base);
                    n_o_max  = 32'(r_hi) + 32'(r_act_base);
                    n_pend   = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_pend     <= 1'b0;
            r_ov       <= 1'b0;
            r_need_w   <= 1'b0;
            r_act_base <= 16'sd0;
            r_act_span <= '0;
            r_live     <= '0;
            r_mc       <= '0;
            r_k        <= '0;
        end else begin
            r_state    <= n_state;
            r_pend     <= n_pend;
            r_ov       <= n_ov;
            r_need_w   <= n_need_w;
            r_act_base <= n_act_base;
            r_act_span <= n_act_span;
            r_live     <= n_live;
            r_mc       <= n_mc;
            r_k        <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_off    <= n_off;
        r_i      <= n_i;
        r_b      <= n_b;
        r_j      <= n_j;
        r_ok     <= n_ok;
        r_sel    <= n_sel;
        r_ev     <= n_ev;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_ml     <= n_ml;
        r_mh     <= n_mh;
        r_o_ok   <= n_o_ok;
        r_o_sel  <= n_o_sel;
        r_o_ev   <= n_o_ev;
        r_o_size <= n_o_size;
        r_o_min  <= n_o_min;
        r_o_max  <= n_o_max;
    end

    assign o_valid          = r_ov;
    assign o_ok             = r_o_ok;
    assign o_selected_value = r_o_sel;
    assign o_ev_min         = r_o_ev.ev_min;
    assign o_ev_max         = r_o_ev.ev_max;
    assign o_ev_change      = r_o_ev.ev_change;
    assign o_ev_bind        = r_o_ev.ev_bind;
    assign o_domain_size    = r_o_size;
    assign o_cur_min        = r_o_min;
    assign o_cur_max        = r_o_max;

    `SSID_ASSERT_IMP(a_live_in_span, i_clk, i_rst_n, r_state == S_IDLE, r_live <= r_act_span, "live count above span")
    `SSID_ASSERT_IMP(a_marks_in_live, i_clk, i_rst_n, r_state == S_IDLE, r_mc <= r_live, "mark count above live count")
    `SSID_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_valid && o_ready, r_state == S_RD || r_state == S_LOAD, "accepted request not started")
    `SSID_ASSERT_NEXT(a_done_shows, i_clk, i_rst_n, r_state == S_DONE && (!r_ov || i_ready), o_valid && r_state == S_IDLE, "finished request not shown")

endmodule

/* sim/testbench.sv */
module testbench;
    import ssid_pkg::*;

    typedef struct {
        logic        ok;
        logic [31:0] sel;
        logic [3:0]  ev;     // min, max, change, bind
        logic [8:0]  size;
        logic [31:0] lo;
        logic [31:0] hi;
    } t_dom_result;

    localparam int DOM_DEPTH  = 256;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_WAIT = 8;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid;
    logic               o_ready;
    t_req               i_req_type;
    logic signed [31:0] i_value;
    logic               o_valid;
    logic               i_ready;
    logic               o_ok;
    logic signed [31:0] o_selected_value;
    logic               o_ev_min;
    logic               o_ev_max;
    logic               o_ev_change;
    logic               o_ev_bind;
    logic [8:0]         o_domain_size;
    logic signed [31:0] o_cur_min;
    logic signed [31:0] o_cur_max;

    sparse_set_integer_domain u_dut (.*);

    // domain copy kept by the predictor
    int unsigned member_vals[DOM_DEPTH];
    int unsigned member_pos[DOM_DEPTH];
    int unsigned live_cnt;
    int          lo_bound;
    int          hi_bound;
    int unsigned mark_cnt;
    int          mark_lo;
    int          mark_hi;
    int          act_base;
    int unsigned act_span;
    int          cfg_base;
    int unsigned cfg_span;
    int unsigned cfg_strat;
    bit          ev_lo, ev_hi, ev_chg, ev_bnd;

    t_dom_result pending_results[$];
    int          fail_cnt;
    int          idle_cycles;
    int          burst_left;
    int          stall_mode_cnt;
    bit          stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void clear_marks();
        mark_cnt = 0;
        mark_lo  = hi_bound + 1;
        mark_hi  = lo_bound - 1;
    endfunction

    function automatic void swap_members(int unsigned i, int unsigned j);
        int unsigned a, b;
        if (i >= act_span || j >= act_span || i == j) return;
        a = member_vals[i];
        b = member_vals[j];
        member_vals[i] = b;
        member_vals[j] = a;
        if (a < act_span) member_pos[a] = j;
        if (b < act_span) member_pos[b] = i;
    endfunction

    function automatic void domain_init();
        act_base = cfg_base;
        act_span = (cfg_span == 0) ? 1 : (cfg_span > DOM_DEPTH) ? DOM_DEPTH : cfg_span;
        for (int k = 0; k < act_span; k++) begin
            member_vals[k] = k;
            member_pos[k]  = k;
        end
        live_cnt = act_span;
        lo_bound = 0;
        hi_bound = int'(act_span) - 1;
        clear_marks();
    endfunction

    function automatic bit domain_bind(longint off);
        int unsigned i;
        if (off < lo_bound || off > hi_bound) return 1'b0;
        if (off < 0 || off >= act_span) return 1'b0;
        i = member_pos[off];
        if (i >= live_cnt) return 1'b0;
        if (live_cnt == 1) return 1'b1;
        swap_members(i, 0);
        live_cnt = 1;
        if (off != lo_bound) begin lo_bound = int'(off); ev_lo = 1; end
        if (off != hi_bound) begin hi_bound = int'(off); ev_hi = 1; end
        ev_chg = 1;
        ev_bnd = 1;
        return 1'b1;
    endfunction

    function automatic t_dom_result domain_apply(t_req req, logic signed [31:0] v);
        t_dom_result r;
        longint off;
        longint sel;
        bit ok;
        bit found;
        int unsigned i, m;
        int w, lo, hi;
        off = longint'(v) - longint'(act_base);
        sel = 0;
        ok  = 1'b1;
        ev_lo = 0; ev_hi = 0; ev_chg = 0; ev_bnd = 0;
        found = (off >= 0 && off < act_span);
        i = found ? member_pos[off] : 0;
        if (req != REQ_MARK && req != REQ_RESTRICT) clear_marks();
        case (req)
            REQ_INIT: domain_init();
            REQ_SELECT: begin
                if (cfg_strat == STRAT_MIN) sel = lo_bound;
                else if (cfg_strat == STRAT_MAX) sel = hi_bound;
                else sel = member_vals[0];
                sel += act_base;
            end
            REQ_MARK: begin
                if (off >= lo_bound && off <= hi_bound && found && i < live_cnt
                        && i >= mark_cnt) begin
                    swap_members(i, mark_cnt);
                    mark_cnt++;
                    if (off < mark_lo) mark_lo = int'(off);
                    if (off > mark_hi) mark_hi = int'(off);
                end
            end
            REQ_BIND: ok = domain_bind(off);
            REQ_REMOVE: begin
                if (found && i < live_cnt) begin
                    if (live_cnt <= 1) begin
                        ok = 1'b0;
                    end else begin
                        live_cnt--;
                        swap_members(i, live_cnt);
                        if (live_cnt == 1) begin
                            w = int'(member_vals[0]);
                            if (w < lo_bound || w > hi_bound) begin
                                ok = 1'b0;
                            end else begin
                                ev_bnd = 1;
                                if (w != lo_bound) begin lo_bound = w; ev_lo = 1; end
                                if (w != hi_bound) begin hi_bound = w; ev_hi = 1; end
                            end
                        end else begin
                            if (off == lo_bound) begin lo_bound++; ev_lo = 1; end
                            if (off == hi_bound) begin hi_bound--; ev_hi = 1; end
                        end
                        if (ok) ev_chg = 1;
                    end
                end
            end
            REQ_RESTRICT: begin
                m  = mark_cnt;
                lo = mark_lo;
                hi = mark_hi;
                clear_marks();
                if (m != live_cnt) begin
                    live_cnt = m;
                    if (m == 0) begin
                        ok = 1'b0;
                    end else begin
                        if (lo_bound != lo) begin lo_bound = lo; ev_lo = 1; end
                        if (hi_bound != hi) begin hi_bound = hi; ev_hi = 1; end
                        ev_chg = 1;
                        if (m == 1) ev_bnd = 1;
                    end
                end
            end
            REQ_RAISE: begin
                if (off <= lo_bound) ok = 1'b1;
                else if (off > hi_bound) ok = 1'b0;
                else if (off == hi_bound) ok = domain_bind(off);
                else begin
                    lo_bound = int'(off);
                    ev_chg = 1;
                    ev_lo  = 1;
                end
            end
            default: begin
                if (off >= hi_bound) ok = 1'b1;
                else if (off < lo_bound) ok = 1'b0;
                else if (off == lo_bound) ok = domain_bind(off);
                else begin
                    hi_bound = int'(off);
                    ev_chg = 1;
                    ev_hi  = 1;
                end
            end
        endcase
        r.ok   = ok;
        r.sel  = sel[31:0];
        r.ev   = {ev_lo, ev_hi, ev_chg, ev_bnd};
        r.size = live_cnt[8:0];
        r.lo   = 32'(longint'(lo_bound) + longint'(act_base));
        r.hi   = 32'(longint'(hi_bound) + longint'(act_base));
        return r;
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
        fail_cnt++;
    endtask

    // result checker and receiver stall pattern
    always @(posedge i_clk) begin
        t_dom_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b1;
        end else begin
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    report("unexpected result", 0, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_ok !== want.ok) report("ok", o_ok, want.ok);
                    if (o_selected_value !== want.sel)
                        report("selected_value", o_selected_value, want.sel);
                    if ({o_ev_min, o_ev_max, o_ev_change, o_ev_bind} !== want.ev)
                        report("events", {o_ev_min, o_ev_max, o_ev_change, o_ev_bind},
                               want.ev);
                    if (o_domain_size !== want.size)
                        report("domain_size", o_domain_size, want.size);
                    if (o_cur_min !== want.lo) report("cur_min", o_cur_min, want.lo);
                    if (o_cur_max !== want.hi) report("cur_max", o_cur_max, want.hi);
                end
            end
            stall_mode_cnt <= stall_mode_cnt + 1;
            if (stall_mode_cnt % 97 == 0) stall_mode <= $urandom_range(0, 1);
            i_ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no request or result moved");
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_req(t_req req, logic [31:0] v);
        int gap;
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_value    <= v;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(domain_apply(req, v));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic apb_write(t_reg_idx idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_BASE:     cfg_base  = int'(signed'(data[15:0]));
            REG_SPAN:     cfg_span  = data[8:0];
            default:      cfg_strat = data[1:0];
        endcase
    endtask

    task automatic set_domain_cfg(int base, int unsigned spn, int unsigned strat);
        wait_drained();
        apb_write(REG_BASE, base);
        apb_write(REG_SPAN, spn);
        apb_write(REG_STRATEGY, strat);
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return act_base + int'($urandom_range(0, act_span + 1)) - 1;
    endfunction

    // boundary and special cases on the reset domain 0..255
    task automatic test_directed();
        send_req(REQ_SELECT, 0);
        send_req(REQ_MARK, 0);
        send_req(REQ_MARK, 255);
        send_req(REQ_MARK, 300);           // outside, ignored
        send_req(REQ_MARK, -1);
        send_req(REQ_RESTRICT, 0);
        send_req(REQ_SELECT, 0);
        send_req(REQ_REMOVE, 0);           // one value left
        send_req(REQ_INIT, 0);
        send_req(REQ_RAISE, 10);
        send_req(REQ_LOWER, 200);
        send_req(REQ_RAISE, 200);          // hits max: bind
        send_req(REQ_INIT, 0);
        send_req(REQ_RESTRICT, 0);         // no marks: empties
        send_req(REQ_SELECT, 0);           // empty domain
        send_req(REQ_INIT, 0);
        send_req(REQ_BIND, 32'h7fff_ffff);
        send_req(REQ_BIND, 32'h8000_0000);
        send_req(REQ_REMOVE, 1000);
        send_req(REQ_LOWER, -5);
        send_req(REQ_MARK, 3);
        send_req(REQ_MARK, 100);
        send_req(REQ_RESTRICT, 0);
        send_req(REQ_RAISE, 50);
        send_req(REQ_REMOVE, 100);         // survivor below min: fails
    endtask

    task automatic test_config_extremes();
        int          bases[4]  = '{-32768, 32767, -1, 100};
        int unsigned spans[4]  = '{0, 511, 1, 256};
        int unsigned strats[4] = '{STRAT_MIN, STRAT_MAX, 3, STRAT_FIRST};
        for (int s = 0; s < 4; s++) begin
            set_domain_cfg(bases[s], spans[s], strats[s]);
            send_req(REQ_INIT, 0);
            send_req(REQ_SELECT, 0);
            send_req(REQ_MARK, act_base + int'(act_span) - 1);
            send_req(REQ_RESTRICT, 0);
            send_req(REQ_SELECT, 0);
            send_req(REQ_REMOVE, act_base);
        end
    endtask

    task automatic test_random(int n_items);
        int          r;
        int unsigned spans[4] = '{8, 3, 40, 256};
        for (int ph = 0; ph < 4; ph++) begin
            set_domain_cfg($urandom, spans[ph], $urandom_range(0, 3));
            send_req(REQ_INIT, 0);
            for (int n = 0; n < n_items; n++) begin
                if (n == n_items / 3) wait_drained();
                r = $urandom_range(0, 99);
                if (r < 4) send_req(REQ_INIT, $urandom);
                else if (r < 30) send_req(REQ_MARK, pick_value());
                else if (r < 38) send_req(REQ_RESTRICT, $urandom);
                else if (r < 60) send_req(REQ_REMOVE, pick_value());
                else if (r < 64) send_req(REQ_BIND, pick_value());
                else if (r < 72) send_req(REQ_RAISE, pick_value());
                else if (r < 80) send_req(REQ_LOWER, pick_value());
                else if (r < 90) send_req(REQ_SELECT, $urandom);
                else send_req(t_req'($urandom_range(0, 7)), $urandom);
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_valid        = 1'b0;
        i_req_type     = REQ_INIT;
        i_value        = '0;
        fail_cnt       = 0;
        burst_left     = 0;
        stall_mode     = 1'b0;
        stall_mode_cnt = 0;
        cfg_base       = 0;
        cfg_span       = 256;
        cfg_strat      = STRAT_FIRST;
        domain_init();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_extremes();
        test_random(375);

        wait_drained();
        repeat (300) @(posedge i_clk);
        if (fail_cnt == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl
rtl/ssid_pkg.sv
rtl/ssid_ram.sv
rtl/sparse_set_integer_domain.sv
sim/testbench.sv
